### rtl/core/sha1md_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha1md_pkg;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] POS_LEN  = 6'd56;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_P1   = 7'd20;
  localparam logic [6:0] ROUND_P2   = 7'd40;
  localparam logic [6:0] ROUND_P3   = 7'd60;

  localparam logic [2:0] WORD_FIRST = 3'd0;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_80,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_FINAL,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      absorb;
    logic      count_len;
    byte_sel_t sel;
    logic      init_work;
    logic      round;
    logic      final_add;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       round_last;
    logic       out_busy;
  } sts_t;

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < ROUND_P1) begin
      k = 32'h5a827999;
    end else if (rnd < ROUND_P2) begin
      k = 32'h6ed9eba1;
    end else if (rnd < ROUND_P3) begin
      k = 32'h8f1bbcdc;
    end else begin
      k = 32'hca62c1d6;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/core/sha1md_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sha1md_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_kind,
  output logic               in_ready,
  output sha1md_pkg::cmd_t   cmd,
  input  wire sha1md_pkg::sts_t sts
);

  sha1md_pkg::ctrl_state_t state_r, state_nxt;
  sha1md_pkg::ctrl_state_t ret_r, ret_nxt;

  logic pos_last;
  logic pos_len;

  assign pos_last = (sts.pos == sha1md_pkg::POS_LAST);
  assign pos_len  = (sts.pos == sha1md_pkg::POS_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1md_pkg::ST_IDLE;
      ret_r   <= sha1md_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      sha1md_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == sha1md_pkg::KIND_FINISH) begin
            state_nxt = sha1md_pkg::ST_PAD_80;
          end else if (pos_last) begin
            state_nxt = sha1md_pkg::ST_ROUND;
            ret_nxt   = sha1md_pkg::ST_IDLE;
          end
        end
      end
      sha1md_pkg::ST_PAD_80: begin
        if (pos_last) begin
          state_nxt = sha1md_pkg::ST_ROUND;
          ret_nxt   = sha1md_pkg::ST_PAD_ZERO;
        end else begin
          state_nxt = sha1md_pkg::ST_PAD_ZERO;
        end
      end
      sha1md_pkg::ST_PAD_ZERO: begin
        if (pos_len) begin
          state_nxt = sha1md_pkg::ST_PAD_LEN;
        end else if (pos_last) begin
          state_nxt = sha1md_pkg::ST_ROUND;
          ret_nxt   = sha1md_pkg::ST_PAD_ZERO;
        end
      end
      sha1md_pkg::ST_PAD_LEN: begin
        if (pos_last) begin
          state_nxt = sha1md_pkg::ST_ROUND;
          ret_nxt   = sha1md_pkg::ST_DONE;
        end
      end
      sha1md_pkg::ST_ROUND: begin
        if (sts.round_last) begin
          state_nxt = sha1md_pkg::ST_FINAL;
        end
      end
      sha1md_pkg::ST_FINAL: begin
        state_nxt = ret_r;
      end
      sha1md_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = sha1md_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sha1md_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.sel  = sha1md_pkg::SEL_DATA;
    unique case (state_r)
      sha1md_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.absorb    = in_valid && (in_kind == sha1md_pkg::KIND_APPEND);
        cmd.count_len = cmd.absorb;
        cmd.init_work = cmd.absorb && pos_last;
      end
      sha1md_pkg::ST_PAD_80: begin
        cmd.absorb    = 1'b1;
        cmd.sel       = sha1md_pkg::SEL_PAD;
        cmd.init_work = pos_last;
      end
      sha1md_pkg::ST_PAD_ZERO: begin
        cmd.absorb    = !pos_len;
        cmd.sel       = sha1md_pkg::SEL_ZERO;
        cmd.init_work = pos_last;
      end
      sha1md_pkg::ST_PAD_LEN: begin
        cmd.absorb    = 1'b1;
        cmd.sel       = sha1md_pkg::SEL_LEN;
        cmd.init_work = pos_last;
      end
      sha1md_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
      end
      sha1md_pkg::ST_FINAL: begin
        cmd.final_add = 1'b1;
      end
      sha1md_pkg::ST_DONE: begin
        cmd.load_out = !sts.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/sha1md_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module sha1md_dpath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sha1md_pkg::cmd_t cmd,
  input  wire logic [7:0]       data_byte,
  input  wire logic             out_ready,
  output sha1md_pkg::sts_t      sts,
  output logic                  out_valid,
  output logic [31:0]           out_word,
  output logic [2:0]            out_index,
  output logic                  out_last
);

  // Block buffer: word i sits at [511-32i -: 32]; bytes shift in at the bottom.
  // During compression it doubles as the 16-word message schedule window.
  logic [511:0] blk_r, blk_nxt;
  logic [31:0]  h_r    [5];
  logic [31:0]  work_r [5];
  logic [31:0]  ow_r   [5];
  logic [5:0]   pos_r;
  logic [63:0]  len_r;
  logic [6:0]   rnd_r;
  logic [2:0]   cnt_r;
  logic         out_valid_r;

  logic [7:0]  in_byte;
  logic [31:0] w0, w2, w8, w13, w_new, x;
  logic [31:0] f, t;
  logic        out_hs;

  always_comb begin
    case (cmd.sel)
      sha1md_pkg::SEL_DATA: in_byte = data_byte;
      sha1md_pkg::SEL_PAD:  in_byte = sha1md_pkg::PAD_BYTE;
      sha1md_pkg::SEL_ZERO: in_byte = 8'h00;
      sha1md_pkg::SEL_LEN:  in_byte = len_r[{3'd7 - pos_r[2:0], 3'b000} +: 8];
      default:              in_byte = 8'h00;
    endcase
  end

  assign w0    = blk_r[511:480];
  assign w2    = blk_r[447:416];
  assign w8    = blk_r[255:224];
  assign w13   = blk_r[95:64];
  assign x     = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {x[30:0], x[31]};

  always_comb begin
    if (cmd.absorb) begin
      blk_nxt = {blk_r[503:0], in_byte};
    end else if (cmd.round) begin
      blk_nxt = {blk_r[479:0], w_new};
    end else begin
      blk_nxt = blk_r;
    end
  end

  always_comb begin
    if (rnd_r < sha1md_pkg::ROUND_P1) begin
      f = ((work_r[2] ^ work_r[3]) & work_r[1]) ^ work_r[3];
    end else if (rnd_r < sha1md_pkg::ROUND_P2) begin
      f = work_r[1] ^ work_r[2] ^ work_r[3];
    end else if (rnd_r < sha1md_pkg::ROUND_P3) begin
      f = (work_r[1] & work_r[2]) | (work_r[3] & (work_r[1] | work_r[2]));
    end else begin
      f = work_r[1] ^ work_r[2] ^ work_r[3];
    end
  end

  assign t = {work_r[0][26:0], work_r[0][31:27]} + f + work_r[4] + w0
             + sha1md_pkg::round_k(rnd_r);

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (cmd.init_work) begin
      for (int i = 0; i < 5; i++) begin
        work_r[i] <= h_r[i];
      end
    end else if (cmd.round) begin
      work_r[0] <= t;
      work_r[1] <= work_r[0];
      work_r[2] <= {work_r[1][1:0], work_r[1][31:2]};
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= sha1md_pkg::H_INIT[i];
      end
      pos_r <= '0;
      len_r <= '0;
      rnd_r <= '0;
    end else begin
      if (cmd.load_out) begin
        for (int i = 0; i < 5; i++) begin
          h_r[i] <= sha1md_pkg::H_INIT[i];
        end
      end else if (cmd.final_add) begin
        for (int i = 0; i < 5; i++) begin
          h_r[i] <= h_r[i] + work_r[i];
        end
      end
      if (cmd.load_out) begin
        pos_r <= '0;
      end else if (cmd.absorb) begin
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.load_out) begin
        len_r <= '0;
      end else if (cmd.count_len) begin
        len_r <= len_r + 64'd8;
      end
      if (cmd.init_work) begin
        rnd_r <= '0;
      end else if (cmd.round) begin
        rnd_r <= rnd_r + 7'd1;
      end
    end
  end

  // Digest output register: word 0 is presented, shifts down per transaction.
  assign out_hs = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int i = 0; i < 5; i++) begin
        ow_r[i] <= h_r[i];
      end
    end else if (out_hs) begin
      for (int i = 0; i < 4; i++) begin
        ow_r[i] <= ow_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
      cnt_r       <= sha1md_pkg::WORD_FIRST;
    end else if (out_hs) begin
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == sha1md_pkg::WORD_LAST) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.pos        = pos_r;
  assign sts.round_last = (rnd_r == sha1md_pkg::ROUND_LAST);
  assign sts.out_busy   = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_word  = ow_r[0];
  assign out_index = cnt_r;
  assign out_last  = (cnt_r == sha1md_pkg::WORD_LAST);

endmodule

`default_nettype wire

### rtl/core/sha1_message_digest_core.sv
// SHA-1 over a byte stream, one byte per input transaction.
// Input: in_tdata carries the message byte, in_tuser the kind (0 append, 1 finish);
// data is ignored on finish. Output: five transactions per finish, out_tdata is the
// digest word, out_tuser its index 0..4, out_tlast marks the fifth word.
// The 64th byte of a block starts the compression: the rounds run on a single
// round unit, then the chaining add, during which in_tready is low.
// A finish pads one byte per cycle (0x80, zeros to byte 56, eight length bytes),
// pausing while a full block is compressed and running one or two compressions
// in all, until the digest is loaded and out_tvalid rises; then the words leave
// at one per cycle while out_tready is high.
// The digest sits in an output register, so appends for the next message are
// accepted while the receiver stalls; a second finish completes its hash and
// waits to load until the previous five words have been taken.
// Reset (rst_n low, synchronous) restores the initial chaining values and clears
// the byte and length counters; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_digest_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [2:0]       out_tuser,  // [2:0] word_index
  output logic             out_tlast
);

  sha1md_pkg::cmd_t cmd;
  sha1md_pkg::sts_t sts;

  sha1md_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sha1md_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_tdata),
    .out_ready (out_tready),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_word  (out_tdata),
    .out_index (out_tuser),
    .out_last  (out_tlast)
  );

  // last word transaction drains the output register
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("output still valid after last digest word");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= sha1md_pkg::WORD_LAST))
    else $error("digest word index out of range");

  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (out_tuser == sha1md_pkg::WORD_FIRST))
    else $error("digest run does not start at word 0");

  a_load_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (sts.pos == '0) && out_tvalid)
    else $error("digest load did not restart message state");

  a_no_accept_in_round: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round |-> !in_tready)
    else $error("input accepted during compression");

endmodule

`default_nettype wire

### dv/sha1_message_digest_core_tb.sv
`timescale 1ns / 1ps

module sha1_message_digest_core_tb;

  localparam int RANDOM_ITEMS = 160;
  localparam int MIN_RANDOM_MSGS = 8;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int TAIL_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  class digest_scoreboard;
    typedef struct packed {
      logic [31:0] word;
      logic [2:0]  idx;
      logic        last;
    } digest_word_t;

    logic [31:0]  chain [5];
    logic [31:0]  blk [16];
    logic [5:0]   pos;
    logic [63:0]  bit_len;
    digest_word_t expected_words [$];
    int unsigned  err_count;

    function new();
      clear_state();
      err_count = 0;
    endfunction

    function void clear_state();
      for (int i = 0; i < 5; i++) chain[i] = sha1md_pkg::H_INIT[i];
      for (int i = 0; i < 16; i++) blk[i] = '0;
      pos = '0;
      bit_len = '0;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = ((c ^ d) & b) ^ d;
          k = 32'h5a827999;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = 32'h6ed9eba1;
        end else if (i < 60) begin
          f = (b & c) | (d & (b | c));
          k = 32'h8f1bbcdc;
        end else begin
          f = b ^ c ^ d;
          k = 32'hca62c1d6;
        end
        t = rotl(a, 5) + f + e + w[i] + k;
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void absorb(logic [7:0] byte_val);
      logic [3:0] widx;
      widx = pos[5:2];
      blk[widx] = {blk[widx][23:0], byte_val};
      pos = pos + 6'd1;
      if (pos == 6'd0) compress();
    endfunction

    // Called once per accepted input transaction.
    function void note_input(logic kind, logic [7:0] data);
      logic [63:0]  len;
      digest_word_t dw;
      if (kind == sha1md_pkg::KIND_APPEND) begin
        absorb(data);
        bit_len += 64'd8;
      end else begin
        // length is latched before padding bytes go in
        len = bit_len;
        absorb(sha1md_pkg::PAD_BYTE);
        while (pos != sha1md_pkg::POS_LEN) absorb(8'h00);
        for (int i = 0; i < 8; i++) absorb(len[63 - 8*i -: 8]);
        for (int i = 0; i < 5; i++) begin
          dw.word = chain[i];
          dw.idx = i[2:0];
          dw.last = (i[2:0] == sha1md_pkg::WORD_LAST);
          expected_words.push_back(dw);
        end
        clear_state();
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      err_count++;
    endtask

    task check_result(logic [31:0] word, logic [2:0] idx, logic last);
      digest_word_t dw;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %08h idx %0d", word, idx));
      end else begin
        dw = expected_words.pop_front();
        if (word !== dw.word)
          report_mismatch($sformatf("digest_word %08h, want %08h (idx %0d)",
                                    word, dw.word, dw.idx));
        if (idx !== dw.idx)
          report_mismatch($sformatf("word_index %0d, want %0d", idx, dw.idx));
        if (last !== dw.last)
          report_mismatch($sformatf("last_word %0b, want %0b (idx %0d)",
                                    last, dw.last, dw.idx));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] digest_word
  logic [2:0]  out_tuser;  // [2:0] word_index
  logic        out_tlast;

  digest_scoreboard sb;
  int          items_sent;
  int          results_taken;
  int          burst_left;
  bit          no_idle;
  bit          held_once;

  sha1_message_digest_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sha1_message_digest_core regression: fail");
    $finish;
  end

  // Called at a rising edge; returns after the item is taken and any idle gap.
  task send_item(logic kind, logic [7:0] data);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_input(kind, data);
    items_sent++;
    if (!no_idle) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  task send_message(int len);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) send_item(sha1md_pkg::KIND_APPEND, 8'($urandom));
    // data field is don't-care on finish, keep it random
    send_item(sha1md_pkg::KIND_FINISH, 8'($urandom));
  endtask

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser, out_tlast);
      results_taken++;
    end
  end

  // Receiver backpressure
  initial begin
    int mode;
    int run_len;
    out_tready <= 1'b0;
    held_once = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      mode = $urandom_range(0, 2);
      run_len = $urandom_range(16, 96);
      for (int i = 0; i < run_len; i++) begin
        if (!held_once && results_taken >= 10) begin
          // long hold-off so a second digest backs up and in_tready drops
          out_tready <= 1'b0;
          repeat (LONG_HOLD_CYCLES) @(posedge clk);
          held_once = 1'b1;
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int random_items;
    int random_msgs;
    int len;
    int drain;
    sb = new();
    items_sent = 0;
    results_taken = 0;
    burst_left = 0;
    no_idle = 1'b1;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    in_tuser <= sha1md_pkg::KIND_APPEND;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message with junk data on finish, back-to-back empty
    send_item(sha1md_pkg::KIND_FINISH, 8'ha5);
    send_item(sha1md_pkg::KIND_FINISH, 8'hff);
    // "abc"
    send_item(sha1md_pkg::KIND_APPEND, 8'h61);
    send_item(sha1md_pkg::KIND_APPEND, 8'h62);
    send_item(sha1md_pkg::KIND_APPEND, 8'h63);
    send_item(sha1md_pkg::KIND_FINISH, 8'h00);
    // byte extremes
    send_item(sha1md_pkg::KIND_APPEND, 8'h00);
    send_item(sha1md_pkg::KIND_FINISH, 8'h5a);
    send_item(sha1md_pkg::KIND_APPEND, 8'hff);
    send_item(sha1md_pkg::KIND_FINISH, 8'hff);
    send_item(sha1md_pkg::KIND_APPEND, 8'h80);
    send_item(sha1md_pkg::KIND_APPEND, 8'h7f);
    send_item(sha1md_pkg::KIND_FINISH, 8'h01);

    // Random messages; some sit on the padding and block boundaries
    random_items = 0;
    random_msgs = 0;
    while (random_items < RANDOM_ITEMS || random_msgs < MIN_RANDOM_MSGS) begin
      if ($urandom_range(0, 4) == 0) len = BOUNDARY_LENS[$urandom_range(0, 7)];
      else len = $urandom_range(0, 12);
      send_message(len);
      random_items += len + 1;
      random_msgs++;
    end
    in_tvalid <= 1'b0;

    drain = 0;
    while (sb.pending() > 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() > 0)
      sb.report_mismatch($sformatf("%0d digest words never arrived", sb.pending()));

    if (sb.err_count == 0) begin
      $display("sha1_message_digest_core regression: pass");
    end else begin
      $display("sha1_message_digest_core regression: fail");
    end
    $finish;
  end

endmodule
